// File: rtl/core/klca_pkg.sv
// Shared types, constants and codes of the keyframe light color animator.
package klca_pkg;

    localparam int MAX_KEYS_DEF  = 8;
    localparam int TIME_BITS_DEF = 16;

    localparam int OP_W       = 2;
    localparam int DUR_W      = 16;
    localparam int KCNT_W     = 4;
    localparam int KEY_SLOT_W = 3;
    localparam int CH_W       = 8;
    localparam int COL_W      = 3 * CH_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_VAL_W  = 16;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_ACT   = 2'd2;
    localparam logic [OP_W-1:0] OP_DEACT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_LIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ACTIVE = 3'd4;

    localparam logic [DUR_W-1:0]  DUR_RESET  = 16'd1000;
    localparam logic [KCNT_W-1:0] KCNT_RESET = 4'd1;

    // Red in the top lane, blue in the bottom lane.
    typedef logic [2:0][CH_W-1:0] t_rgb;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [DUR_W-1:0]      elapsed_ms;
        logic [KEY_SLOT_W-1:0] key_slot;
        logic [DUR_W-1:0]      key_start_ms;
        logic [CH_W-1:0]       key_red;
        logic [CH_W-1:0]       key_green;
        logic [CH_W-1:0]       key_blue;
    } t_in_item;

    typedef struct packed {
        logic [KEY_SLOT_W-1:0] current_key;
        logic [CH_W-1:0]       out_red;
        logic [CH_W-1:0]       out_green;
        logic [CH_W-1:0]       out_blue;
        logic                  is_active;
        logic                  changed;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_VAL_W-1:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic accept;
        logic act_sw;
        logic set_time;
        logic mod_init;
        logic mod_step;
        logic time_rem;
        logic rd;
        logic take;
        logic nxt;
        logic wrap;
        logic col_cur;
        logic bl_set;
        logic col_nxt;
        logic mul_a;
        logic mul_b;
        logic div_init;
        logic div_step;
        logic col_q;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            go;
        logic            need_mod;
        logic            act_same;
        logic            mod_last;
        logic            cur_last;
        logic            ramp;
        logic            hit;
        logic            bl_skip;
        logic            div_last;
    } t_dp_stat;

endpackage

// File: rtl/core/klca_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
interface klca_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/klca_dp.sv
// Datapath: settings, light state, keyframe memory, modulo and blend dividers.
module klca_dp import klca_pkg::*; #(
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    input  logic      i_cfg_wr,
    input  t_cfg_item i_cfg,
    output t_dp_stat  o_stat,
    output t_out_item o_res
);
    localparam int KEY_W = $clog2(MAX_KEYS);
    localparam int KC_W  = $clog2(MAX_KEYS + 1);
    localparam int SUM_W = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
    localparam int MC_W  = $clog2(SUM_W + 1);
    localparam int ENT_W = DUR_W + COL_W;
    localparam int ACC_W = CH_W + DUR_W;
    localparam int REM_W = ACC_W + 1;
    localparam int DC_W  = $clog2(CH_W + 1);
    localparam logic [DUR_W-1:0] TMASK = (TIME_BITS >= DUR_W) ? {DUR_W{1'b1}} :
                                         DUR_W'((1 << TIME_BITS) - 1);

    // Settings
    logic [DUR_W-1:0]  r_dur;
    logic [KCNT_W-1:0] r_kcnt;
    logic              r_ramp;
    logic              r_alarm_light;
    logic              r_alarm_on;

    // Light state
    logic                 r_active;
    logic [TIME_BITS-1:0] r_time;
    logic [KEY_W-1:0]     r_key;
    t_rgb                 r_color;
    t_rgb                 r_key0_col;

    // Item latch and old values for the change flag
    logic [OP_W-1:0]  r_op;
    logic [DUR_W-1:0] r_ms;
    logic [KEY_W-1:0] r_old_key;
    t_rgb             r_old_col;
    logic             r_old_act;

    // Keyframe memory: start time above color
    logic [ENT_W-1:0] r_mem [MAX_KEYS];
    logic [ENT_W-1:0] r_rd;

    // Working registers
    logic [DUR_W-1:0] r_t;
    logic [SUM_W-1:0] r_dvd;
    logic [DUR_W-1:0] r_rem;
    logic [MC_W-1:0]  r_mcnt;
    logic [KC_W-1:0]  r_idx;
    logic [KEY_W-1:0] r_cur;
    logic [DUR_W-1:0] r_cur_time;
    t_rgb             r_cur_col;
    logic [DUR_W-1:0] r_nxt_time;
    t_rgb             r_nxt_col;
    logic [DUR_W-1:0] r_into;
    logic [DUR_W-1:0] r_tot;
    logic [ACC_W-1:0] r_acc [3];
    logic [REM_W-1:0] r_brem [3];
    logic [ACC_W-1:0] r_dv;
    t_rgb             r_q;
    logic [DC_W-1:0]  r_dcnt;
    t_out_item        r_res;

    logic [DUR_W-1:0] dur_eff;
    logic [KC_W-1:0]  cnt_eff;
    logic [SUM_W-1:0] sum;
    logic [DUR_W-1:0] t_direct;
    logic [DUR_W-1:0] t_new;
    logic [DUR_W-1:0] t_new_m;
    logic [DUR_W:0]   rem_shift;
    logic [DUR_W:0]   rem_sub;
    logic             rem_ge;
    logic [DUR_W-1:0] rem_nx;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    logic [DUR_W-1:0] wr_time;
    logic [DUR_W-1:0] rd_time;
    t_rgb             rd_col;
    logic [DUR_W-1:0] wa;
    logic [ACC_W-1:0] prod [3];
    logic             div_ge [3];

    always_comb begin
        dur_eff = (r_dur == '0) ? DUR_W'(1) : r_dur;
        if (r_kcnt == '0) begin
            cnt_eff = KC_W'(1);
        end else if (32'(r_kcnt) > MAX_KEYS) begin
            cnt_eff = KC_W'(MAX_KEYS);
        end else begin
            cnt_eff = KC_W'(r_kcnt);
        end
    end

    assign sum = SUM_W'(r_time) + SUM_W'(r_ms);

    // Ramp clamps at the duration; a looping sum below the duration needs no modulo.
    assign t_direct = (r_ramp && (sum > SUM_W'(dur_eff))) ? dur_eff : sum[DUR_W-1:0];
    assign t_new    = i_cmd.time_rem ? r_rem : t_direct;
    assign t_new_m  = t_new & TMASK;

    // One restoring remainder step per cycle, dividend MSB first.
    assign rem_shift = {r_rem, r_dvd[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dur_eff};
    assign rem_sub   = rem_shift - {1'b0, dur_eff};
    assign rem_nx    = rem_ge ? rem_sub[DUR_W-1:0] : rem_shift[DUR_W-1:0];

    assign wr_en   = i_cmd.accept && (i_item.operation == OP_WRITE) &&
                     (32'(i_item.key_slot) < MAX_KEYS);
    assign wr_addr = KEY_W'(i_item.key_slot);
    assign wr_time = (i_item.key_slot == '0) ? '0 : i_item.key_start_ms;
    assign rd_time = r_rd[ENT_W-1:COL_W];
    assign rd_col  = t_rgb'(r_rd[COL_W-1:0]);
    assign wa      = r_tot - r_into;

    // One shared multiplier per channel: weight of the current key, then of the next.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = i_cmd.mul_a ? (ACC_W'(r_cur_col[c]) * ACC_W'(wa))
                                  : (ACC_W'(r_nxt_col[c]) * ACC_W'(r_into));
            div_ge[c] = r_brem[c] >= REM_W'(r_dv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur         <= DUR_RESET;
            r_kcnt        <= KCNT_RESET;
            r_ramp        <= 1'b0;
            r_alarm_light <= 1'b0;
            r_alarm_on    <= 1'b0;
        end else if (i_cfg_wr) begin
            case (i_cfg.idx)
                REG_DURATION:     r_dur         <= i_cfg.value[DUR_W-1:0];
                REG_KEY_COUNT:    r_kcnt        <= i_cfg.value[KCNT_W-1:0];
                REG_RAMP_MODE:    r_ramp        <= i_cfg.value[0];
                REG_ALARM_LIGHT:  r_alarm_light <= i_cfg.value[0];
                REG_ALARM_ACTIVE: r_alarm_on    <= i_cfg.value[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_time   <= '0;
            r_key    <= '0;
            r_color  <= '0;
        end else begin
            if (i_cmd.act_sw) begin
                r_active <= (r_op == OP_ACT);
                r_time   <= '0;
                r_key    <= '0;
                r_color  <= r_key0_col;
            end
            if (i_cmd.set_time || i_cmd.time_rem) begin
                r_time <= TIME_BITS'(t_new_m);
            end
            if (i_cmd.col_cur) begin
                r_key   <= r_cur;
                r_color <= r_cur_col;
            end
            if (i_cmd.col_nxt) begin
                r_key   <= r_cur;
                r_color <= r_nxt_col;
            end
            if (i_cmd.col_q) begin
                r_key   <= r_cur;
                r_color <= r_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {wr_time, i_item.key_red, i_item.key_green, i_item.key_blue};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx[KEY_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (i_item.key_slot == '0)) begin
            r_key0_col <= t_rgb'({i_item.key_red, i_item.key_green, i_item.key_blue});
        end
        if (i_cmd.accept) begin
            r_op      <= i_item.operation;
            r_ms      <= i_item.elapsed_ms;
            r_old_key <= r_key;
            r_old_col <= r_color;
            r_old_act <= r_active;
        end
        if (i_cmd.mod_init) begin
            r_dvd  <= sum;
            r_rem  <= '0;
            r_mcnt <= MC_W'(SUM_W);
        end
        if (i_cmd.mod_step) begin
            r_dvd  <= r_dvd << 1;
            r_rem  <= rem_nx;
            r_mcnt <= r_mcnt - MC_W'(1);
        end
        // Setting the time also starts the key search at key 0.
        if (i_cmd.set_time || i_cmd.time_rem) begin
            r_t        <= t_new_m;
            r_idx      <= KC_W'(1);
            r_cur      <= '0;
            r_cur_time <= '0;
            r_cur_col  <= r_key0_col;
        end
        if (i_cmd.take) begin
            r_cur      <= r_idx[KEY_W-1:0];
            r_cur_time <= rd_time;
            r_cur_col  <= rd_col;
            r_idx      <= r_idx + KC_W'(1);
        end
        if (i_cmd.nxt) begin
            r_nxt_time <= rd_time;
            r_nxt_col  <= rd_col;
        end
        if (i_cmd.wrap) begin
            r_nxt_time <= dur_eff;
            r_nxt_col  <= r_key0_col;
        end
        if (i_cmd.bl_set) begin
            r_into <= r_t - r_cur_time;
            r_tot  <= r_nxt_time - r_cur_time;
        end
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.mul_a) begin
                r_acc[c] <= prod[c];
            end
            if (i_cmd.mul_b) begin
                r_acc[c] <= r_acc[c] + prod[c];
            end
            // Rounded quotient (2*num + tot) / (2*tot); it never exceeds one channel.
            if (i_cmd.div_init) begin
                r_brem[c] <= {r_acc[c], 1'b0} + REM_W'(r_tot);
                r_q[c]    <= '0;
            end
            if (i_cmd.div_step) begin
                r_brem[c] <= div_ge[c] ? (r_brem[c] - REM_W'(r_dv)) : r_brem[c];
                r_q[c]    <= {r_q[c][CH_W-2:0], div_ge[c]};
            end
        end
        if (i_cmd.div_init) begin
            r_dv   <= {r_tot, CH_W'(0)};
            r_dcnt <= DC_W'(CH_W);
        end
        if (i_cmd.div_step) begin
            r_dv   <= r_dv >> 1;
            r_dcnt <= r_dcnt - DC_W'(1);
        end
        if (i_cmd.out_load) begin
            r_res.current_key <= KEY_SLOT_W'(r_key);
            r_res.out_red     <= r_color[2];
            r_res.out_green   <= r_color[1];
            r_res.out_blue    <= r_color[0];
            r_res.is_active   <= r_active;
            r_res.changed     <= (r_key != r_old_key) || (r_color != r_old_col) ||
                                 (r_active != r_old_act);
        end
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.go       = r_alarm_on ? r_alarm_light : (r_active && !r_alarm_light);
        o_stat.need_mod = !r_ramp && (sum >= SUM_W'(dur_eff));
        o_stat.act_same = r_active == (r_op == OP_ACT);
        o_stat.mod_last = r_mcnt == MC_W'(1);
        o_stat.cur_last = r_idx == cnt_eff;
        o_stat.ramp     = r_ramp;
        o_stat.hit      = rd_time <= r_t;
        o_stat.bl_skip  = (r_tot == '0) || (r_into >= r_tot);
        o_stat.div_last = r_dcnt == DC_W'(1);
    end

    assign o_res = r_res;

endmodule

// File: rtl/core/klca_ctrl.sv
// Controller: sequences item acceptance, time update, key search, blend and result.
module klca_ctrl import klca_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_out_valid,
    input  logic     i_out_ready
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_MODEND = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_BSET   = 4'd6;
    localparam logic [3:0] S_BCHK   = 4'd7;
    localparam logic [3:0] S_MULB   = 4'd8;
    localparam logic [3:0] S_DINIT  = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_COLQ   = 4'd11;
    localparam logic [3:0] S_RES    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_TICK: begin
                        if (!i_stat.go) begin
                            n_state = S_RES;
                        end else if (i_stat.need_mod) begin
                            o_cmd.mod_init = 1'b1;
                            n_state        = S_MOD;
                        end else begin
                            o_cmd.set_time = 1'b1;
                            n_state        = S_RD;
                        end
                    end
                    OP_WRITE: n_state = S_RES;
                    default: begin
                        o_cmd.act_sw = !i_stat.act_same;
                        n_state      = S_RES;
                    end
                endcase
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_MODEND;
                end
            end
            S_MODEND: begin
                o_cmd.time_rem = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                // The current key is the last one in use: ramp holds it, looping wraps to key 0.
                if (i_stat.cur_last) begin
                    if (i_stat.ramp) begin
                        o_cmd.col_cur = 1'b1;
                        n_state       = S_RES;
                    end else begin
                        o_cmd.wrap = 1'b1;
                        n_state    = S_BSET;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_RD;
                end else begin
                    o_cmd.nxt = 1'b1;
                    n_state   = S_BSET;
                end
            end
            S_BSET: begin
                o_cmd.bl_set = 1'b1;
                n_state      = S_BCHK;
            end
            S_BCHK: begin
                if (i_stat.bl_skip) begin
                    o_cmd.col_nxt = 1'b1;
                    n_state       = S_RES;
                end else begin
                    o_cmd.mul_a = 1'b1;
                    n_state     = S_MULB;
                end
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_COLQ;
                end
            end
            S_COLQ: begin
                o_cmd.col_q = 1'b1;
                n_state     = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/keyframe_light_color_animator_top.sv
// Top level of the keyframe light color animator.
//
// Channels: i_item takes one item per valid/ready handshake (tick, keyframe
// write, activate or deactivate); o_result returns exactly one item for each
// accepted item, in order; i_cfg writes one setting register per handshake
// and is always ready. Settings must be written only while the block is
// idle; the block itself does not enforce it. A keyframe write, an activate,
// a deactivate or a gated tick goes straight to the result. An active tick
// reads the keys one by one: a ramp that reaches its last key holds it;
// otherwise the search ends at a later key or wraps to key 0, and a blend
// may follow. A looping time that wraps first runs the remainder divider
// over the W bits of the time sum, W being the wider of 16 and TIME_BITS
// plus one. The wrap remainder divider and the blend divider are bit
// serial, one bit per cycle.
// One item is worked on at a time; the next one is accepted as soon as the
// result sits in the output register, even while the receiver stalls it.
// Reset clears the light state and restores the default settings; the
// keyframe table holds no defined contents until written.
module keyframe_light_color_animator_top import klca_pkg::*; #(
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    klca_stream_if.sink   i_item,
    klca_stream_if.source o_result,
    klca_stream_if.sink   i_cfg
);
    t_dp_cmd   cmd;
    t_dp_stat  stat;
    t_out_item res;

    klca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready)
    );

    klca_dp #(
        .MAX_KEYS  (MAX_KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item.data),
        .i_cfg_wr (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .o_stat   (stat),
        .o_res    (res)
    );

    assign i_cfg.ready   = 1'b1;
    assign o_result.data = res;

endmodule
